FILE: hw/rtl/bbs_pkg.sv
// Package for the 3x3 box blur stream: payload structs, configuration codes and limits.
// Used by every module of the block but bbs_ram; depends on nothing.
`default_nettype none
package bbs_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUR_ROWS    = 2'd2;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
        logic [7:0] in_alpha;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [7:0] out_alpha;
        logic       frame_end;
    } out_word_t;

    // Packed pixel with blue in the low byte
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // Effective frame geometry after clamping
    typedef struct packed {
        logic [COL_W:0] width;   // 1..MAX_WIDTH
        logic [ROW_W:0] height;  // 1..MAX_HEIGHT
        logic [12:0]    blur;
    } geom_t;

    // Column of original pixels handed from front to back
    typedef struct packed {
        pixel_t top;   // two rows up
        pixel_t mid;   // one row up
        pixel_t bot;   // newest row
        logic   emit;
    } col_entry_t;

    // ceil(2^16 / n) for n = 1..9; exact floor division for sums below 4096
    function automatic logic [16:0] recip(input logic [3:0] n);
        logic [16:0] r;
        case (n)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            4'd9:    r = 17'd7282;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/bbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/bbs_front.sv
// Front end: accepts input words, tracks the input slot, reads and updates the two
// line stores and hands one pixel column per slot to the queue. Uses bbs_pkg, bbs_ram.
`default_nettype none
module bbs_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               restart,
    input  wire bbs_pkg::geom_t     geom,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire bbs_pkg::in_word_t  in_data,
    output logic                    push,
    output bbs_pkg::col_entry_t     push_entry,
    input  wire logic               q_full
);
    import bbs_pkg::*;

    typedef enum logic {F_IDLE, F_WRITE} fstate_t;

    fstate_t          state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W:0]   row_reg, row_next;
    pixel_t           pix_reg, pix_next;
    logic             emit_reg, emit_next;
    logic             last_reg, last_next;

    pixel_t rd_prev, rd_prev2;
    logic   accept, pixel_slot, rd_en, wr_en;

    assign pixel_slot = row_reg < geom.height;
    assign accept     = (state_reg == F_IDLE) && in_valid;
    assign in_stall   = (state_reg != F_IDLE);
    assign rd_en      = accept && !(pixel_slot && in_data.func == FUNC_FLUSH);
    assign wr_en      = (state_reg == F_WRITE) && !q_full;

    bbs_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_prev (
        .clk(clk), .we(wr_en), .waddr(col_reg), .wdata(pix_reg),
        .re(rd_en), .raddr(col_reg), .rdata(rd_prev)
    );

    bbs_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_prev2 (
        .clk(clk), .we(wr_en), .waddr(col_reg), .wdata(rd_prev),
        .re(rd_en), .raddr(col_reg), .rdata(rd_prev2)
    );

    assign push             = wr_en;
    assign push_entry.top   = rd_prev2;
    assign push_entry.mid   = rd_prev;
    assign push_entry.bot   = pix_reg;
    assign push_entry.emit  = emit_reg;

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        pix_next   = pix_reg;
        emit_next  = emit_reg;
        last_next  = last_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (rd_en)
                begin
                    pix_next = pixel_slot ?
                        pixel_t'{in_data.in_alpha, in_data.in_red,
                                 in_data.in_green, in_data.in_blue} : '0;
                    emit_next = (row_reg >= (ROW_W+1)'(2)) ||
                                (row_reg == (ROW_W+1)'(1) && col_reg != '0);
                    last_next = ({1'b0, row_reg} == {1'b0, geom.height} + (ROW_W+2)'(1))
                                && col_reg == '0;
                    state_next = F_WRITE;
                end
            end
            F_WRITE:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                    if (last_reg)
                    begin
                        col_next = '0;
                        row_next = '0;
                    end
                    else if ({1'b0, col_reg} + (COL_W+1)'(1) >= geom.width)
                    begin
                        col_next = '0;
                        row_next = row_reg + (ROW_W+1)'(1);
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
            end
            default: state_next = F_IDLE;
        endcase
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            emit_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            emit_reg  <= emit_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
    end
endmodule
`default_nettype wire

FILE: hw/rtl/bbs_fifo.sv
// Two-entry queue of pixel columns between front and back end.
// Uses bbs_pkg.
`default_nettype none
module bbs_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire bbs_pkg::col_entry_t  push_entry,
    output logic                      full,
    input  wire logic                 pop,
    output bbs_pkg::col_entry_t       pop_entry,
    output logic                      empty
);
    import bbs_pkg::*;

    col_entry_t slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign full      = cnt_reg == 2'd2;
    assign empty     = cnt_reg == 2'd0;
    assign pop_entry = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_entry;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/bbs_back.sv
// Back end: holds the 3x3 window, sums the in-frame neighbours, divides by the
// count through a reciprocal multiply and drives the output register. Uses bbs_pkg.
`default_nettype none
module bbs_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 restart,
    input  wire bbs_pkg::geom_t       geom,
    input  wire logic                 q_empty,
    output logic                      pop,
    input  wire bbs_pkg::col_entry_t  pop_entry,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output bbs_pkg::out_word_t        out_data
);
    import bbs_pkg::*;

    typedef enum logic [1:0] {B_IDLE, B_SUM, B_MUL} bstate_t;

    bstate_t            state_reg;
    pixel_t             win_reg [6];  // 0..2 centre column, 3..5 left column
    col_entry_t         ent_reg;
    logic [COL_W-1:0]   ocol_reg;
    logic [ROW_W-1:0]   orow_reg;
    logic [11:0]        sum_reg [4];
    logic [3:0]         cnt_reg;
    logic               pass_reg;
    pixel_t             cpix_reg;
    logic               last_reg;
    logic               out_valid_reg;
    out_word_t          out_reg;

    logic       cv [3];
    logic       rv [3];
    pixel_t     nb [9];
    logic [11:0] sum_c [4];
    logic [3:0]  cnt_c;
    logic        blurred, last_c, col_wrap, out_free;
    logic [28:0] prod [4];
    logic [16:0] rcp;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pop       = (state_reg == B_IDLE) && !q_empty;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        cv[0] = ocol_reg != '0;
        cv[1] = 1'b1;
        cv[2] = {1'b0, ocol_reg} + (COL_W+1)'(1) < geom.width;
        rv[0] = orow_reg != '0;
        rv[1] = 1'b1;
        rv[2] = {1'b0, orow_reg} + (ROW_W+1)'(1) < geom.height;
        nb[0] = win_reg[3];
        nb[1] = win_reg[4];
        nb[2] = win_reg[5];
        nb[3] = win_reg[0];
        nb[4] = win_reg[1];
        nb[5] = win_reg[2];
        nb[6] = ent_reg.top;
        nb[7] = ent_reg.mid;
        nb[8] = ent_reg.bot;
        cnt_c = '0;
        for (int k = 0; k < 4; k++)
        begin
            sum_c[k] = '0;
        end
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (cv[j] && rv[i])
                begin
                    cnt_c    = cnt_c + 4'd1;
                    sum_c[0] = sum_c[0] + 12'(nb[3*j+i].blue);
                    sum_c[1] = sum_c[1] + 12'(nb[3*j+i].green);
                    sum_c[2] = sum_c[2] + 12'(nb[3*j+i].red);
                    sum_c[3] = sum_c[3] + 12'(nb[3*j+i].alpha);
                end
            end
        end
        blurred  = {1'b0, orow_reg} < geom.blur;
        last_c   = ({1'b0, orow_reg} + (ROW_W+1)'(1) == geom.height) &&
                   ({1'b0, ocol_reg} + (COL_W+1)'(1) == geom.width);
        col_wrap = {1'b0, ocol_reg} + (COL_W+1)'(1) >= geom.width;
        rcp = recip(cnt_reg);
        for (int k = 0; k < 4; k++)
        begin
            prod[k] = sum_reg[k] * rcp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            ocol_reg      <= '0;
            orow_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 6; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            if (state_reg == B_MUL && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (restart)
            begin
                ocol_reg <= '0;
                orow_reg <= '0;
                for (int k = 0; k < 6; k++)
                begin
                    win_reg[k] <= '0;
                end
            end
            else
            begin
                unique case (state_reg)
                    B_IDLE:
                    begin
                        if (pop)
                        begin
                            if (pop_entry.emit)
                            begin
                                state_reg <= B_SUM;
                            end
                            else
                            begin
                                // advance the window without a result
                                win_reg[3] <= win_reg[0];
                                win_reg[4] <= win_reg[1];
                                win_reg[5] <= win_reg[2];
                                win_reg[0] <= pop_entry.top;
                                win_reg[1] <= pop_entry.mid;
                                win_reg[2] <= pop_entry.bot;
                            end
                        end
                    end
                    B_SUM:
                    begin
                        state_reg <= B_MUL;
                        if (last_c)
                        begin
                            ocol_reg <= '0;
                            orow_reg <= '0;
                            for (int k = 0; k < 6; k++)
                            begin
                                win_reg[k] <= '0;
                            end
                        end
                        else
                        begin
                            win_reg[3] <= win_reg[0];
                            win_reg[4] <= win_reg[1];
                            win_reg[5] <= win_reg[2];
                            win_reg[0] <= ent_reg.top;
                            win_reg[1] <= ent_reg.mid;
                            win_reg[2] <= ent_reg.bot;
                            if (col_wrap)
                            begin
                                ocol_reg <= '0;
                                orow_reg <= orow_reg + ROW_W'(1);
                            end
                            else
                            begin
                                ocol_reg <= ocol_reg + COL_W'(1);
                            end
                        end
                    end
                    B_MUL:
                    begin
                        if (out_free)
                        begin
                            state_reg <= B_IDLE;
                        end
                    end
                    default: state_reg <= B_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg <= pop_entry;
        end
        if (state_reg == B_SUM)
        begin
            for (int k = 0; k < 4; k++)
            begin
                sum_reg[k] <= sum_c[k];
            end
            cnt_reg  <= cnt_c;
            pass_reg <= !blurred;
            cpix_reg <= win_reg[1];
            last_reg <= last_c;
        end
        if (state_reg == B_MUL && out_free)
        begin
            if (pass_reg)
            begin
                out_reg.out_blue  <= cpix_reg.blue;
                out_reg.out_green <= cpix_reg.green;
                out_reg.out_red   <= cpix_reg.red;
                out_reg.out_alpha <= cpix_reg.alpha;
            end
            else
            begin
                out_reg.out_blue  <= prod[0][23:16];
                out_reg.out_green <= prod[1][23:16];
                out_reg.out_red   <= prod[2][23:16];
                out_reg.out_alpha <= prod[3][23:16];
            end
            out_reg.frame_end <= last_reg;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/box_blur_3x3_stream.sv
// Top level of the streaming 3x3 box blur: configuration registers, front end,
// column queue and back end. Uses bbs_pkg, bbs_front, bbs_fifo, bbs_back.
//
// Usage: words enter on in_valid/in_stall/in_data in raster order, one per
// frame pixel, then frame_width+1 flush words (func = 1) to drain the frame.
// A flush word in a pixel slot is dropped; pixel data in a flush slot is ignored.
// Results leave on out_valid/out_stall/out_data, one per pixel in raster order,
// starting once one row plus two pixels have entered; frame_end marks the last.
// In the front end each word passes a line store read, then write back and queue
// push; the back end takes each result through pop, window sum and reciprocal
// multiply, and only pops a word without a result. Once results flow, the back
// end sets the pace.
// While the receiver stalls, the output register holds and the two-entry queue
// fills; the front end then holds in_stall high.
// Reset clears counters, window and registers to 640x480 with 240 blurred rows;
// line stores are not cleared and need no clearing pass. A register write on
// cfg_we restarts the frame; write only while the block is idle.
`default_nettype none
module box_blur_3x3_stream (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire bbs_pkg::in_word_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output bbs_pkg::out_word_t                  out_data,
    input  wire logic                           cfg_we,
    input  wire logic [bbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bbs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bbs_pkg::*;

    logic [11:0] width_reg;
    logic [12:0] height_reg;
    logic [12:0] blur_reg;
    logic        restart;
    geom_t       geom;

    logic       push, pop, q_full, q_empty;
    col_entry_t push_entry, pop_entry;

    assign restart = cfg_we && (cfg_index == REG_FRAME_WIDTH ||
                                cfg_index == REG_FRAME_HEIGHT ||
                                cfg_index == REG_BLUR_ROWS);

    always_comb
    begin
        if (width_reg == '0)
        begin
            geom.width = (COL_W+1)'(1);
        end
        else if ({1'b0, width_reg} > 13'(MAX_WIDTH))
        begin
            geom.width = (COL_W+1)'(MAX_WIDTH);
        end
        else
        begin
            geom.width = (COL_W+1)'(width_reg);
        end
        if (height_reg == '0)
        begin
            geom.height = (ROW_W+1)'(1);
        end
        else if ({1'b0, height_reg} > 14'(MAX_HEIGHT))
        begin
            geom.height = (ROW_W+1)'(MAX_HEIGHT);
        end
        else
        begin
            geom.height = (ROW_W+1)'(height_reg);
        end
        geom.blur = blur_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 12'd640;
            height_reg <= 13'd480;
            blur_reg   <= 13'd240;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data[11:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                REG_BLUR_ROWS:    blur_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    bbs_front u_front (
        .clk(clk), .rst_n(rst_n), .restart(restart), .geom(geom),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .push(push), .push_entry(push_entry), .q_full(q_full)
    );

    bbs_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .push(push), .push_entry(push_entry),
        .full(q_full), .pop(pop), .pop_entry(pop_entry), .empty(q_empty)
    );

    bbs_back u_back (
        .clk(clk), .rst_n(rst_n), .restart(restart), .geom(geom),
        .q_empty(q_empty), .pop(pop), .pop_entry(pop_entry),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_full))
        else $error("column pushed into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_empty))
        else $error("column popped from empty queue");
    a_push_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> in_stall)
        else $error("queue push without a word in the front end");
`endif
endmodule
`default_nettype wire

FILE: tb/tb_box_blur_3x3_stream.sv
// Self-checking testbench for box_blur_3x3_stream: directed table, then random frames.
// Depends on bbs_pkg and the box_blur_3x3_stream RTL only.
`timescale 1ns / 1ps
module tb_box_blur_3x3_stream;
    import bbs_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_word_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_word_t             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    box_blur_3x3_stream DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // idle modes: 0 none, 1 sender 86%, 2 receiver 86%, 3 both 28%
    int        idle_mode = 0;
    int        n_errors = 0;
    int        words_sent = 0;
    out_word_t blur_expected[$];

    // blur state
    logic [31:0] row_above[MAX_WIDTH];
    logic [31:0] row_above2[MAX_WIDTH];
    logic [31:0] win[6];
    int unsigned in_col, in_row, out_col, out_row;
    int unsigned frame_w = 640, frame_h = 480, blur_lim = 240;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned lim);
        if (v == 0)
            return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic int unsigned eff_w();
        return clamp_dim(frame_w, MAX_WIDTH);
    endfunction

    function automatic int unsigned eff_h();
        return clamp_dim(frame_h, MAX_HEIGHT);
    endfunction

    function automatic void restart_frame();
        for (int i = 0; i < 6; i++)
            win[i] = '0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    // Advance the blur state by one accepted word; returns 1 with the pixel it emits.
    function automatic bit blur_step(input in_word_t w, output out_word_t res_word);
        int unsigned wd, ht, r, c, cnt, sum;
        logic [31:0] newpix, res;
        logic [31:0] ncol[3];
        logic [31:0] cols[3][3];
        bit rv[3], cv[3];
        bit last, emit;
        wd = eff_w();
        ht = eff_h();
        last = 1'b0;
        emit = 1'b0;
        res_word = '0;
        if (in_row < ht && w.func == FUNC_FLUSH)
            return 1'b0;
        newpix = (in_row < ht) ? {w.in_alpha, w.in_red, w.in_green, w.in_blue} : 32'h0;
        ncol[0] = row_above2[in_col];
        ncol[1] = row_above[in_col];
        ncol[2] = newpix;
        row_above2[in_col] = row_above[in_col];
        row_above[in_col] = newpix;
        if (in_row >= 2 || (in_row == 1 && in_col >= 1)) begin
            r = out_row;
            c = out_col;
            res = win[1];
            if (r < blur_lim) begin
                rv[0] = r >= 1; rv[1] = 1'b1; rv[2] = (r + 1) < ht;
                cv[0] = c >= 1; cv[1] = 1'b1; cv[2] = (c + 1) < wd;
                for (int i = 0; i < 3; i++)
                begin
                    cols[0][i] = win[3 + i];
                    cols[1][i] = win[i];
                    cols[2][i] = ncol[i];
                end
                cnt = 0;
                for (int j = 0; j < 3; j++)
                    for (int i = 0; i < 3; i++)
                        if (cv[j] && rv[i])
                            cnt++;
                for (int sh = 0; sh < 32; sh += 8)
                begin
                    sum = 0;
                    for (int j = 0; j < 3; j++)
                        for (int i = 0; i < 3; i++)
                            if (cv[j] && rv[i])
                                sum += (cols[j][i] >> sh) & 8'hFF;
                    res[sh +: 8] = 8'((sum / cnt) & 8'hFF);
                end
            end
            last = (r == ht - 1) && (c == wd - 1);
            res_word.out_blue  = res[7:0];
            res_word.out_green = res[15:8];
            res_word.out_red   = res[23:16];
            res_word.out_alpha = res[31:24];
            res_word.frame_end = last;
            emit = 1'b1;
            out_col++;
            if (out_col >= wd)
            begin
                out_col = 0;
                out_row++;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            win[3 + i] = win[i];
            win[i] = ncol[i];
        end
        in_col++;
        if (in_col >= wd)
        begin
            in_col = 0;
            in_row++;
        end
        if (last)
            restart_frame();
        return emit;
    endfunction

    function automatic bit roll(int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Send one word; a typed expectation, if given, replaces the predicted one.
    task automatic send_word(input in_word_t w, input bit has_typed, input out_word_t typed);
        out_word_t res;
        int p;
        p = (idle_mode == 1) ? 86 : (idle_mode == 3) ? 28 : 0;
        if (roll(p))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (roll(p))
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        if (blur_step(w, res))
            blur_expected.push_back(has_typed ? typed : res);
    endtask

    task automatic send_pred(input in_word_t w);
        send_word(w, 1'b0, '0);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (blur_expected.size() != 0)
            @(posedge clk);
        // a flush dropped in a pixel slot may still be in flight
        repeat (16) @(posedge clk);
    endtask

    task automatic write_geometry(input int unsigned w, input int unsigned h,
                                  input int unsigned b);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= CFG_DATA_W'(w);
        @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= CFG_DATA_W'(h);
        @(posedge clk);
        cfg_index <= REG_BLUR_ROWS;
        cfg_data  <= CFG_DATA_W'(b);
        @(posedge clk);
        cfg_we <= 1'b0;
        frame_w  = w & 12'hFFF;
        frame_h  = h & 13'h1FFF;
        blur_lim = b & 13'h1FFF;
        restart_frame();
    endtask

    function automatic in_word_t rand_pixel();
        in_word_t w;
        w = in_word_t'({1'b0, $urandom()});
        case ($urandom_range(7))
            0: w[31:0] = 32'h0;
            1: w[31:0] = 32'hFFFF_FFFF;
            default: ;
        endcase
        return w;
    endfunction

    // One frame: pixel slots with occasional dropped flushes, then the flush slots.
    task automatic run_frame(input bit noisy, input bit pause_mid, input bit abort);
        int unsigned npix, nflush, stop;
        in_word_t w;
        npix = eff_w() * eff_h();
        nflush = eff_w() + 1;
        stop = abort ? $urandom_range(npix + nflush - 1) : npix + nflush;
        for (int unsigned k = 0; k < stop; k++)
        begin
            if (pause_mid && k == npix / 2)
                wait_drained();
            if (k < npix)
            begin
                if (noisy && roll(6))
                    send_pred(in_word_t'({FUNC_FLUSH, $urandom()}));
                send_pred(rand_pixel());
            end
            else
            begin
                w = rand_pixel();
                if (!noisy || !roll(15))
                    w.func = FUNC_FLUSH;
                send_pred(w);
            end
        end
    endtask

    // receiver stall
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= roll((idle_mode == 2) ? 86 : (idle_mode == 3) ? 28 : 0);
    end

    // result check
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (blur_expected.size() == 0)
            begin
                $error("unexpected result word %h", out_data);
                n_errors++;
            end
            else
            begin
                e = blur_expected.pop_front();
                if (out_data.out_blue !== e.out_blue)
                begin
                    $error("out_blue: expected %h, got %h", e.out_blue, out_data.out_blue);
                    n_errors++;
                end
                if (out_data.out_green !== e.out_green)
                begin
                    $error("out_green: expected %h, got %h", e.out_green, out_data.out_green);
                    n_errors++;
                end
                if (out_data.out_red !== e.out_red)
                begin
                    $error("out_red: expected %h, got %h", e.out_red, out_data.out_red);
                    n_errors++;
                end
                if (out_data.out_alpha !== e.out_alpha)
                begin
                    $error("out_alpha: expected %h, got %h", e.out_alpha, out_data.out_alpha);
                    n_errors++;
                end
                if (out_data.frame_end !== e.frame_end)
                begin
                    $error("frame_end: expected %b, got %b", e.frame_end, out_data.frame_end);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving either way
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 3000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        in_word_t  dir_in[8];
        out_word_t dir_exp[8];
        bit        dir_has[8];
        int        frame_no;
        int unsigned w, h, b;
        restart_frame();
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            row_above[i] = '0;
            row_above2[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 2x2 pass-through frame: results are the input pixels, one row plus one late
        dir_in[0] = {FUNC_FLUSH, 32'h1234_5678};   // dropped in a pixel slot
        dir_in[1] = {FUNC_PIXEL, 32'h0000_0000};
        dir_in[2] = {FUNC_PIXEL, 32'hFFFF_FFFF};
        dir_in[3] = {FUNC_PIXEL, 32'h0180_7FFE};
        dir_in[4] = {FUNC_PIXEL, 32'hA55A_C33C};
        dir_in[5] = {FUNC_FLUSH, 32'h0};
        dir_in[6] = {FUNC_PIXEL, 32'hDEAD_BEEF};   // data dropped in a flush slot
        dir_in[7] = {FUNC_FLUSH, 32'h0};
        dir_has = '{0, 0, 0, 0, 1, 1, 1, 1};
        dir_exp[4] = {32'h0000_0000, 1'b0};
        dir_exp[5] = {32'hFFFF_FFFF, 1'b0};
        dir_exp[6] = {32'h0180_7FFE, 1'b0};
        dir_exp[7] = {32'hA55A_C33C, 1'b1};
        write_geometry(2, 2, 0);
        for (int i = 0; i < 8; i++)
            send_word(dir_in[i], dir_has[i], dir_exp[i]);

        // unused register index: no effect
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(3);
        cfg_data  <= '1;
        @(posedge clk);
        cfg_we <= 1'b0;

        // all-white 3x3 fully blurred, then single pixel and zero sizes
        write_geometry(3, 3, 8191);
        for (int i = 0; i < 9; i++)
            send_pred({FUNC_PIXEL, 32'hFFFF_FFFF});
        for (int i = 0; i < 4; i++)
            send_pred({FUNC_FLUSH, 32'h0});
        write_geometry(1, 1, 1);
        run_frame(1'b0, 1'b0, 1'b0);
        write_geometry(0, 0, 4096);
        run_frame(1'b0, 1'b0, 1'b0);

        // largest sizes: the head of a frame each, the rest is cut by the next write
        write_geometry(4095, 1, 1);
        repeat (40) send_pred(rand_pixel());
        write_geometry(2048, 2, 1);
        repeat (40) send_pred(rand_pixel());
        write_geometry(1, 8191, 4095);
        repeat (40) send_pred(rand_pixel());
        write_geometry(3, 4096, 2);
        idle_mode = 3;
        repeat (40) send_pred(rand_pixel());

        // random frames, small sizes, cycling through idle modes
        frame_no = 0;
        while (words_sent < 550)
        begin
            idle_mode = (frame_no / 3) % 4;
            if (frame_no % 5 != 4)
            begin
                w = $urandom_range(1, 7);
                h = $urandom_range(1, 6);
                b = roll(15) ? 0 : roll(15) ? 8191 : $urandom_range(0, h + 1);
                write_geometry(w, h, b);
            end
            run_frame(1'b1, frame_no % 7 == 0, roll(8));
            frame_no++;
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
